// ===== sv/cluster_bounds_and_size_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Cluster bounds and size filter: assertion macros
// Check wrappers shared by the block; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_BOUNDS_AND_SIZE_FILTER_DEFINES_SVH
`define CLUSTER_BOUNDS_AND_SIZE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// cond true now implies expr true in the same cycle
`define CBSF_ASSERT_NOW(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("cbsf: check failed in the same cycle");
// cond true now implies expr true in the next cycle
`define CBSF_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("cbsf: check failed in the following cycle");
`else
`define CBSF_ASSERT_NOW(lbl, cond, expr)
`define CBSF_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

// ===== sv/cbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Cluster bounds and size filter: package
// Widths, types and register indexes shared by the interfaces and the block.
// ----------------------------------------------------------------------------
package cbsf_pkg;

  localparam int COORD_BITS = 20;
  localparam int MAX_POINTS = 65536;
  localparam int EXT_BITS   = 20;
  localparam int AXES_BITS  = 2;
  localparam int NUM_AXES   = 3;

  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int SUM_BITS   = COORD_BITS + $clog2(MAX_POINTS);
  localparam int STEP_BITS  = $clog2(SUM_BITS);
  localparam int CMP_BITS   = (COORD_BITS > EXT_BITS) ? COORD_BITS : EXT_BITS;
  localparam int IDX_BITS   = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [EXT_BITS-1:0]          ext_t;
  typedef logic [AXES_BITS-1:0]         axes_t;
  typedef logic [1:0]                   axis_idx_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_X_EXT_MIN   = 3'd0,
    REG_X_EXT_MAX   = 3'd1,
    REG_Y_EXT_MIN   = 3'd2,
    REG_Y_EXT_MAX   = 3'd3,
    REG_Z_EXT_MIN   = 3'd4,
    REG_Z_EXT_MAX   = 3'd5,
    REG_AXES_NEEDED = 3'd6
  } cfg_reg_t;

  localparam ext_t  EXT_MIN_RESET     = '0;
  localparam ext_t  EXT_MAX_RESET     = '1;
  localparam axes_t AXES_NEEDED_RESET = axes_t'(3);

endpackage

// ===== sv/cbsf_point_if.sv =====
// ----------------------------------------------------------------------------
// Cluster bounds and size filter: point channel
// One point of a cluster per item, last point marked.
// ----------------------------------------------------------------------------
interface cbsf_point_if import cbsf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t px;
  coord_t py;
  coord_t pz;
  logic   last_point;

  modport source (output valid, px, py, pz, last_point, input ready);
  modport sink   (input valid, px, py, pz, last_point, output ready);
endinterface

// ===== sv/cbsf_result_if.sv =====
// ----------------------------------------------------------------------------
// Cluster bounds and size filter: result channel
// Centroid, bounds and size flag of one finished cluster per item.
// ----------------------------------------------------------------------------
interface cbsf_result_if import cbsf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t centroid_x;
  coord_t centroid_y;
  coord_t centroid_z;
  coord_t min_x;
  coord_t min_y;
  coord_t min_z;
  coord_t max_x;
  coord_t max_y;
  coord_t max_z;
  logic   size_ok;

  modport source (output valid, centroid_x, centroid_y, centroid_z, min_x, min_y, min_z,
                  max_x, max_y, max_z, size_ok, input ready);
  modport sink   (input valid, centroid_x, centroid_y, centroid_z, min_x, min_y, min_z,
                  max_x, max_y, max_z, size_ok, output ready);
endinterface

// ===== sv/cluster_bounds_and_size_filter.sv =====
// ----------------------------------------------------------------------------
// Cluster bounds and size filter
// Bounding box, centroid and extent check over the points of one cluster.
// ----------------------------------------------------------------------------
// An ordinary point is taken at once: min, max, sums and count update as it
// is accepted. After the point marked last, no point is taken until a single
// restoring divider has worked out the three centroid axes one after the
// other, one quotient bit per cycle. The result then sits in an output
// register, and points of the next cluster are taken while it waits; a
// further last point waits for the register to empty before its result is
// loaded.
`include "cluster_bounds_and_size_filter_defines.svh"

module cluster_bounds_and_size_filter import cbsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [IDX_BITS-1:0]   cfg_index,
  input  logic [EXT_BITS-1:0]   cfg_wdata,
  cbsf_point_if.sink            points,
  cbsf_result_if.source         results
);

  typedef enum logic [3:0] {
    ST_ACCUM = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  ext_t  ext_min [NUM_AXES];
  ext_t  ext_max [NUM_AXES];
  axes_t axes_needed;

  coord_t low_corner  [NUM_AXES];
  coord_t high_corner [NUM_AXES];
  sum_t   coord_sums  [NUM_AXES];
  cnt_t   point_count;

  coord_t low_next  [NUM_AXES];
  coord_t high_next [NUM_AXES];
  sum_t   sums_next [NUM_AXES];
  coord_t pt        [NUM_AXES];

  // shared divider
  axis_idx_t             axis;
  logic [SUM_BITS-1:0]   dvd, dvd_next;
  cnt_t                  rem, rem_next;
  logic [STEP_BITS-1:0]  step;
  logic                  neg;
  logic [CNT_BITS:0]     trial;
  logic                  trial_ge;
  sum_t                  sum_sel;
  coord_t                quot_low;
  coord_t                cen [NUM_AXES];

  logic [AXES_BITS-1:0]  passed;
  logic                  size_ok_calc;
  logic                  pt_acc;
  logic                  out_load;

  assign pt[0] = points.px;
  assign pt[1] = points.py;
  assign pt[2] = points.pz;

  assign points.ready = (state == ST_ACCUM);
  assign pt_acc       = points.valid && points.ready;
  assign out_load     = (state == ST_DONE) && (!results.valid || results.ready);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        ext_min[a] <= EXT_MIN_RESET;
        ext_max[a] <= EXT_MAX_RESET;
      end
      axes_needed <= AXES_NEEDED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_EXT_MIN:   ext_min[0]  <= cfg_wdata;
        REG_X_EXT_MAX:   ext_max[0]  <= cfg_wdata;
        REG_Y_EXT_MIN:   ext_min[1]  <= cfg_wdata;
        REG_Y_EXT_MAX:   ext_max[1]  <= cfg_wdata;
        REG_Z_EXT_MIN:   ext_min[2]  <= cfg_wdata;
        REG_Z_EXT_MAX:   ext_max[2]  <= cfg_wdata;
        REG_AXES_NEEDED: axes_needed <= cfg_wdata[AXES_BITS-1:0];
        default: ;
      endcase
    end
  end

  // per-point update; first point of a cluster overwrites the corners
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      if (point_count == '0) begin
        low_next[a]  = pt[a];
        high_next[a] = pt[a];
      end else begin
        low_next[a]  = (pt[a] < low_corner[a])  ? pt[a] : low_corner[a];
        high_next[a] = (pt[a] > high_corner[a]) ? pt[a] : high_corner[a];
      end
      sums_next[a] = coord_sums[a] + {{(SUM_BITS-COORD_BITS){pt[a][COORD_BITS-1]}}, pt[a]};
    end
  end

  // extent check
  always_comb begin
    logic [COORD_BITS-1:0] extent;
    logic [CMP_BITS-1:0]   ext_w;
    passed = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      extent = COORD_BITS'(high_corner[a] - low_corner[a]);
      ext_w  = CMP_BITS'(extent);
      if (ext_w >= CMP_BITS'(ext_min[a]) && ext_w <= CMP_BITS'(ext_max[a]))
        passed = passed + AXES_BITS'(1);
    end
    size_ok_calc = (passed >= axes_needed);
  end

  // divider step
  assign sum_sel  = coord_sums[axis];
  assign trial    = {rem, dvd[SUM_BITS-1]};
  assign trial_ge = (trial >= {1'b0, point_count});
  assign rem_next = trial_ge ? CNT_BITS'(trial - {1'b0, point_count})
                             : trial[CNT_BITS-1:0];
  assign dvd_next = {dvd[SUM_BITS-2:0], trial_ge};
  assign quot_low = neg ? -coord_t'(dvd_next[COORD_BITS-1:0])
                        : coord_t'(dvd_next[COORD_BITS-1:0]);

  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: if (pt_acc && points.last_point) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV: begin
        if (step == '0) state_next = (axis == axis_idx_t'(NUM_AXES - 1)) ? ST_DONE : ST_LOAD;
      end
      ST_DONE:  if (out_load) state_next = ST_ACCUM;
      default:  state_next = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_ACCUM;
      axis        <= '0;
      point_count <= '0;
      for (int a = 0; a < NUM_AXES; a++) coord_sums[a] <= '0;
    end else begin
      state <= state_next;
      if (pt_acc) begin
        // hold sums and count once saturated
        if (point_count < CNT_BITS'(MAX_POINTS)) begin
          for (int a = 0; a < NUM_AXES; a++) coord_sums[a] <= sums_next[a];
          point_count <= point_count + CNT_BITS'(1);
        end
      end else if (state == ST_DIV && step == '0) begin
        axis <= (axis == axis_idx_t'(NUM_AXES - 1)) ? '0 : axis + axis_idx_t'(1);
      end else if (out_load) begin
        for (int a = 0; a < NUM_AXES; a++) coord_sums[a] <= '0;
        point_count <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pt_acc) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        low_corner[a]  <= low_next[a];
        high_corner[a] <= high_next[a];
      end
    end
    case (state)
      ST_LOAD: begin
        neg  <= sum_sel[SUM_BITS-1];
        dvd  <= sum_sel[SUM_BITS-1] ? SUM_BITS'(-sum_sel) : SUM_BITS'(sum_sel);
        rem  <= '0;
        step <= STEP_BITS'(SUM_BITS - 1);
      end
      ST_DIV: begin
        dvd  <= dvd_next;
        rem  <= rem_next;
        step <= step - STEP_BITS'(1);
        if (step == '0) cen[axis] <= quot_low;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.centroid_x <= cen[0];
      results.centroid_y <= cen[1];
      results.centroid_z <= cen[2];
      results.min_x      <= low_corner[0];
      results.min_y      <= low_corner[1];
      results.min_z      <= low_corner[2];
      results.max_x      <= high_corner[0];
      results.max_y      <= high_corner[1];
      results.max_z      <= high_corner[2];
      results.size_ok    <= size_ok_calc;
    end
  end

  `CBSF_ASSERT_NEXT(a_last_starts_div, pt_acc && points.last_point, state == ST_LOAD)
  `CBSF_ASSERT_NEXT(a_load_clears, out_load, results.valid && point_count == '0)
  `CBSF_ASSERT_NOW(a_count_bound, 1'b1, point_count <= CNT_BITS'(MAX_POINTS))
  `CBSF_ASSERT_NOW(a_div_nonzero, state == ST_DIV || state == ST_LOAD, point_count != '0)

endmodule
